// ===== rtl/bna_pkg.sv =====
package bna_pkg;

	localparam int PIXEL_W  = 8;
	localparam int WORD_W   = 32;
	localparam int TERM_W   = 9;
	localparam int ACC_W    = 19;
	localparam int SUM_W    = ACC_W + 1;
	localparam int OFFSET_W = 11;
	localparam int CNT_W    = $clog2(WORD_W + 1);

	localparam logic [OFFSET_W-1:0] OFFSET_RESET = OFFSET_W'(1010);

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	typedef enum logic {
		OP_PIXEL = 1'b0,
		OP_WORD  = 1'b1
	} op_t;

	typedef enum logic {
		REG_POPCOUNT_OFFSET = 1'b0
	} reg_idx_t;

	// term handed from the term stage to the accumulator stage
	typedef struct packed {
		op_t                       opcode;
		logic                      last;
		logic signed [TERM_W-1:0]  term;
	} term_t;

	function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SUM_W-1:0] v);
		logic signed [ACC_W-1:0] r;
		if (v > SUM_W'(ACC_MAX))
			r = ACC_MAX;
		else if (v < SUM_W'(ACC_MIN))
			r = ACC_MIN;
		else
			r = v[ACC_W-1:0];
		return r;
	endfunction

endpackage

// ===== rtl/bna_term.sv =====
module bna_term (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  bna_pkg::op_t                 opcode,
	input  logic [bna_pkg::PIXEL_W-1:0]  pixel,
	input  logic                         weight_bit,
	input  logic [bna_pkg::WORD_W-1:0]   act_word,
	input  logic [bna_pkg::WORD_W-1:0]   weight_word,
	input  logic                         last,
	input  logic                         take,
	output logic                         term_valid,
	output bna_pkg::term_t               term_s2
);
	import bna_pkg::*;

	logic                valid_s1;
	op_t                 opcode_s1;
	logic [PIXEL_W-1:0]  pixel_s1;
	logic                weight_bit_s1;
	logic [WORD_W-1:0]   act_word_s1;
	logic [WORD_W-1:0]   weight_word_s1;
	logic                last_s1;

	logic                valid_s2;
	logic                adv1;
	logic [WORD_W-1:0]   xnor_w;
	logic [CNT_W-1:0]    ones;
	logic signed [TERM_W-1:0] term_d;

	assign adv1     = valid_s1 && (!valid_s2 || take);
	assign in_ready = !valid_s1 || adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				valid_s1 <= 1'b1;
			else if (adv1)
				valid_s1 <= 1'b0;
			if (adv1)
				valid_s2 <= 1'b1;
			else if (take)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			opcode_s1      <= opcode;
			pixel_s1       <= pixel;
			weight_bit_s1  <= weight_bit;
			act_word_s1    <= act_word;
			weight_word_s1 <= weight_word;
			last_s1        <= last;
		end
		if (adv1) begin
			term_s2.opcode <= opcode_s1;
			term_s2.last   <= last_s1;
			term_s2.term   <= term_d;
		end
	end

	assign xnor_w = ~(act_word_s1 ^ weight_word_s1);

	always_comb begin
		ones = '0;
		for (int i = 0; i < WORD_W; i++)
			ones = ones + CNT_W'(xnor_w[i]);
	end

	always_comb begin
		unique case (opcode_s1)
			OP_WORD:  term_d = $signed({{(TERM_W-CNT_W-1){1'b0}}, ones, 1'b0});
			OP_PIXEL: term_d = weight_bit_s1 ? $signed({1'b0, pixel_s1})
			                                 : -$signed({1'b0, pixel_s1});
			default:  term_d = '0;
		endcase
	end

	assign term_valid = valid_s2;

endmodule

// ===== rtl/bna_accum.sv =====
module bna_accum (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          term_valid,
	input  bna_pkg::term_t                term_s2,
	output logic                          take,
	input  logic [bna_pkg::OFFSET_W-1:0]  offset,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [bna_pkg::ACC_W-1:0] score,
	output logic                          active
);
	import bna_pkg::*;

	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] acc_new;
	logic signed [ACC_W-1:0] score_sub;
	logic signed [ACC_W-1:0] score_d;
	logic signed [SUM_W-1:0] sum;
	logic signed [SUM_W-1:0] diff;
	logic                    out_free;
	logic                    emit;

	// a last term needs the output register; other terms only touch the accumulator
	assign out_free = !out_valid || out_ready;
	assign take     = term_valid && (!term_s2.last || out_free);
	assign emit     = take && term_s2.last;

	assign sum     = SUM_W'(acc_q) + SUM_W'(term_s2.term);
	assign acc_new = sat_acc(sum);

	assign diff      = SUM_W'(acc_new) - $signed({{(SUM_W-OFFSET_W){1'b0}}, offset});
	assign score_sub = sat_acc(diff);

	always_comb begin
		unique case (term_s2.opcode)
			OP_WORD:  score_d = score_sub;
			OP_PIXEL: score_d = acc_new;
			default:  score_d = acc_new;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (take)
				acc_q <= term_s2.last ? '0 : acc_new;
			if (emit)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			score  <= score_d;
			active <= !score_d[ACC_W-1];
		end
	end

endmodule

// ===== rtl/binary_neuron_accumulator_core.sv =====
// Binarized-network neuron accumulator. Each transfer on the s_ side is one term of the
// current neuron: tuser = 0 adds or subtracts the 8-bit pixel by its weight bit, tuser = 1
// adds twice the popcount of XNOR(act_word, weight_word). The running sum saturates to
// 19-bit signed. The term with tlast set closes the neuron: one result (score, active)
// goes out on the m_ side, with popcount_offset subtracted (and saturated) when that last
// term is a word term, and the sum restarts at zero. One term is taken every clock while
// no last term is held by a blocked result. The last term passes the input and term
// registers before the output register raises m_tvalid. s_tready drops only while a
// finished result waits in the output register and another last term is in the term stage.
module binary_neuron_accumulator_core (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// term stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,  // pixel[7:0], weight_bit[8], act_word[40:9], weight_word[72:41]
	input  logic        s_tuser,  // opcode
	input  logic        s_tlast,  // last
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata   // score[18:0], active[19]
);
	import bna_pkg::*;

	logic [OFFSET_W-1:0]     offset_q;
	reg_idx_t                reg_idx;
	logic                    term_valid;
	logic                    take;
	term_t                   term_s2;
	logic signed [ACC_W-1:0] score;
	logic                    active;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= OFFSET_RESET;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx)
				REG_POPCOUNT_OFFSET: offset_q <= pwdata[OFFSET_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_POPCOUNT_OFFSET: prdata = {{(32-OFFSET_W){1'b0}}, offset_q};
			default:             prdata = '0;
		endcase
	end

	bna_term u_term (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.opcode      (op_t'(s_tuser)),
		.pixel       (s_tdata[7:0]),
		.weight_bit  (s_tdata[8]),
		.act_word    (s_tdata[40:9]),
		.weight_word (s_tdata[72:41]),
		.last        (s_tlast),
		.take        (take),
		.term_valid  (term_valid),
		.term_s2     (term_s2)
	);

	bna_accum u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.term_valid (term_valid),
		.term_s2    (term_s2),
		.take       (take),
		.offset     (offset_q),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.score      (score),
		.active     (active)
	);

	assign m_tdata = {4'b0, active, score};

`ifndef SYNTH
	// the activation bit always agrees with the sign of the score it travels with
	a_active_sign: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[19] == !m_tdata[18]))
		else $error("active bit disagrees with score sign");

	// input backpressure only comes from a blocked result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("s_tready low without a blocked result");

	// a term stage that is stalled keeps its term for the next cycle
	a_term_held: assert property (@(posedge clk) disable iff (!arst_n)
		(term_valid && !take) |=> (term_valid && $stable(term_s2)))
		else $error("stalled term lost");
`endif

endmodule
